// ===== rtl/nbo_pkg.sv =====
// Shared types, codes and sizes for the NV12 bounding box overlay.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package nbo_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int COORD_BITS = 12;

    localparam int THICK_BITS  = 4;
    localparam int LUMA_BITS   = 8;
    localparam int SAMPLE_BITS = 16;

    localparam logic [THICK_BITS-1:0] THICK_MAX = THICK_BITS'(10);
    localparam logic [THICK_BITS-1:0] THICK_DEF = THICK_BITS'(1);
    localparam logic [LUMA_BITS-1:0] LUMA_COLOR_DEF = '0;
    localparam logic [SAMPLE_BITS-1:0] CHROMA_COLOR_DEF = 16'hFFFF;

    // beat opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_LUMA   = 2'd2;
    localparam logic [1:0] OP_CHROMA = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_THICKNESS    = 2'd0;
    localparam logic [1:0] REG_LUMA_COLOR   = 2'd1;
    localparam logic [1:0] REG_CHROMA_COLOR = 2'd2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } box_t;

    // write request from the pipeline into the box table
    typedef struct packed {
        logic       load;
        logic       clear;
        logic [4:0] slot;
        box_t       box;
    } tbl_wr_t;

    // control shared by all ring lanes
    typedef struct packed {
        logic                  adv2;
        logic                  chroma1;
        logic                  chroma2;
        logic [THICK_BITS-1:0] rings;
    } lane_ctrl_t;

    function automatic coord_t coord_min(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nbo_if.sv =====
// Valid/ready channel interfaces: pixel input, pixel output, register write.
// Depends on nbo_pkg for field widths.
`default_nettype none

interface nbo_in_if;
    import nbo_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             op;
    logic [4:0]             slot;
    coord_t                 box_left;
    coord_t                 box_top;
    coord_t                 box_right;
    coord_t                 box_bottom;
    coord_t                 pos_x;
    coord_t                 pos_y;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, op, slot, box_left, box_top, box_right, box_bottom,
                    pos_x, pos_y, sample_value, input ready);
    modport sink   (input valid, op, slot, box_left, box_top, box_right, box_bottom,
                    pos_x, pos_y, sample_value, output ready);
endinterface

interface nbo_out_if;
    import nbo_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   on_outline;

    modport source (output valid, sample_out, on_outline, input ready);
    modport sink   (input valid, sample_out, on_outline, output ready);
endinterface

interface nbo_cfg_if;
    import nbo_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             index;
    logic [SAMPLE_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/nbo_box_table.sv =====
// Box slot table: corner registers per slot plus valid bits.
// Depends on nbo_pkg; written from stage 1 of the overlay pipeline.
`default_nettype none

module nbo_box_table
    import nbo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tbl_wr_t              wr,
    output box_t                      boxes [NUM_SLOTS],
    output logic [NUM_SLOTS-1:0]      slot_valid
);

    box_t                 box_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    box_t                 even_box;

    // corners snap down to even luma coordinates
    assign even_box.left   = {wr.box.left[COORD_BITS-1:1], 1'b0};
    assign even_box.top    = {wr.box.top[COORD_BITS-1:1], 1'b0};
    assign even_box.right  = {wr.box.right[COORD_BITS-1:1], 1'b0};
    assign even_box.bottom = {wr.box.bottom[COORD_BITS-1:1], 1'b0};

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (wr.load && int'(wr.slot) == k)
            begin
                box_reg[k] <= even_box;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.clear)
        begin
            valid_next = '0;
        end
        else if (wr.load)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (int'(wr.slot) == k)
                begin
                    valid_next[k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign boxes      = box_reg;
    assign slot_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/nbo_ring_lane.sv =====
// One box slot's ring test, stages 1 and 2 of the overlay pipeline.
// Depends on nbo_pkg. Stage 1 takes edge distances, stage 2 finds the ring index.
`default_nettype none

module nbo_ring_lane
    import nbo_pkg::*;
(
    input  wire logic       clk,
    input  wire lane_ctrl_t ctrl,
    input  wire coord_t     pos_x,
    input  wire coord_t     pos_y,
    input  wire box_t       box,
    input  wire logic       box_valid,
    output logic            hit
);

    coord_t                l_sel, t_sel, r_sel, b_sel;
    logic [COORD_BITS:0]   d_l, d_t, d_r, d_b;
    logic                  in_box;

    logic                  live_reg;
    coord_t                near_reg;   // min distance to left/top edge
    coord_t                far_reg;    // min distance to right/bottom edge

    logic [COORD_BITS:0]   ring_idx;
    logic [COORD_BITS:0]   far_x2;

    // chroma works on the halved box
    always_comb
    begin
        if (ctrl.chroma1)
        begin
            l_sel = box.left >> 1;
            t_sel = box.top >> 1;
            r_sel = box.right >> 1;
            b_sel = box.bottom >> 1;
        end
        else
        begin
            l_sel = box.left;
            t_sel = box.top;
            r_sel = box.right;
            b_sel = box.bottom;
        end
        d_l = {1'b0, pos_x} - {1'b0, l_sel};
        d_t = {1'b0, pos_y} - {1'b0, t_sel};
        d_r = {1'b0, r_sel} - {1'b0, pos_x};
        d_b = {1'b0, b_sel} - {1'b0, pos_y};
        in_box = box_valid && !d_l[COORD_BITS] && !d_t[COORD_BITS]
                 && !d_r[COORD_BITS] && !d_b[COORD_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            live_reg <= in_box;
            near_reg <= coord_min(d_l[COORD_BITS-1:0], d_t[COORD_BITS-1:0]);
            far_reg  <= coord_min(d_r[COORD_BITS-1:0], d_b[COORD_BITS-1:0]);
        end
    end

    // Lowest ring through the sample. Luma: plain min of the four distances.
    // Chroma: ring i insets the near edges by floor(i/2), the far edges by ceil(i/2).
    always_comb
    begin
        far_x2 = {far_reg, 1'b0};
        if (!ctrl.chroma2)
        begin
            ring_idx = {1'b0, coord_min(near_reg, far_reg)};
        end
        else if (far_reg <= near_reg)
        begin
            ring_idx = (far_reg != '0) ? far_x2 - (COORD_BITS+1)'(1) : '0;
        end
        else
        begin
            ring_idx = {near_reg, 1'b0};
        end
        hit = live_reg && (ring_idx < (COORD_BITS+1)'(ctrl.rings));
    end

endmodule

`default_nettype wire

// ===== rtl/nv12_bounding_box_overlay.sv =====
// Top level of the NV12 bounding box outline overlay.
// Depends on nbo_pkg, nbo_if, nbo_box_table and nbo_ring_lane.
//
//  channel   modport  beat carries
//  -------   -------  --------------------------------------------------------
//  pix_in    sink     op, slot, box corners, pos_x, pos_y, sample_value
//  pix_out   source   sample_out, on_outline (one beat per luma/chroma sample)
//  cfg       sink     index, data (0 thickness, 1 luma_color, 2 chroma_color)
//
// Four register stages: input, edge distances (one lane per slot), per-slot
// hit vector, output. One beat per cycle while pix_out is ready; a sample passes
// all four registers in order. Loads and clears update the table as they leave
// stage 1 and produce no output beat. Reset empties the table and loads
// register defaults. pix_out stalls back up stage by stage; bubbles are squeezed out.
`default_nettype none

module nv12_bounding_box_overlay
    import nbo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    nbo_in_if.sink    pix_in,
    nbo_out_if.source pix_out,
    nbo_cfg_if.sink   cfg
);

    // configuration
    logic [THICK_BITS-1:0]  thickness_reg;
    logic [LUMA_BITS-1:0]   luma_color_reg;
    logic [SAMPLE_BITS-1:0] chroma_color_reg;
    logic [THICK_BITS-1:0]  rings;

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1
    logic [1:0]             op1_reg;
    logic [4:0]             slot1_reg;
    box_t                   box1_reg;
    coord_t                 x1_reg, y1_reg;
    logic [SAMPLE_BITS-1:0] smp1_reg;
    logic                   is_sample1;

    // stage 2 / 3 / 4
    logic                   chroma2_reg, chroma3_reg;
    logic [SAMPLE_BITS-1:0] smp2_reg, smp3_reg;
    logic [NUM_SLOTS-1:0]   hit_vec;
    logic [NUM_SLOTS-1:0]   hit3_reg;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic [SAMPLE_BITS-1:0] out_next;
    logic                   outline_reg;
    logic                   outline_next;

    tbl_wr_t                tbl_wr;
    lane_ctrl_t             lane_ctrl;
    box_t                   boxes [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   slot_valid;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thickness_reg    <= THICK_DEF;
            luma_color_reg   <= LUMA_COLOR_DEF;
            chroma_color_reg <= CHROMA_COLOR_DEF;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_THICKNESS:    thickness_reg    <= cfg.data[THICK_BITS-1:0];
                REG_LUMA_COLOR:   luma_color_reg   <= cfg.data[LUMA_BITS-1:0];
                REG_CHROMA_COLOR: chroma_color_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign rings = (thickness_reg >= THICK_DEF && thickness_reg <= THICK_MAX)
                   ? thickness_reg : THICK_DEF;

    // ---------------- pipeline control ----------------
    assign en4 = !v4_reg || pix_out.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pix_in.ready = en1;

    assign is_sample1 = (op1_reg == OP_LUMA) || (op1_reg == OP_CHROMA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg && is_sample1;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg         <= pix_in.op;
            slot1_reg       <= pix_in.slot;
            box1_reg.left   <= pix_in.box_left;
            box1_reg.top    <= pix_in.box_top;
            box1_reg.right  <= pix_in.box_right;
            box1_reg.bottom <= pix_in.box_bottom;
            x1_reg          <= pix_in.pos_x;
            y1_reg          <= pix_in.pos_y;
            smp1_reg        <= pix_in.sample_value;
        end
    end

    // table changes as the beat leaves stage 1, after all older samples
    // have read it and before any younger one does
    assign tbl_wr.load  = en2 && v1_reg && (op1_reg == OP_LOAD);
    assign tbl_wr.clear = en2 && v1_reg && (op1_reg == OP_CLEAR);
    assign tbl_wr.slot  = slot1_reg;
    assign tbl_wr.box   = box1_reg;

    nbo_box_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr),
        .boxes      (boxes),
        .slot_valid (slot_valid)
    );

    // ---------------- stages 1-2: per-slot lanes ----------------
    assign lane_ctrl.adv2    = en2;
    assign lane_ctrl.chroma1 = (op1_reg == OP_CHROMA);
    assign lane_ctrl.chroma2 = chroma2_reg;
    assign lane_ctrl.rings   = rings;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_lane
        nbo_ring_lane u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .pos_x     (x1_reg),
            .pos_y     (y1_reg),
            .box       (boxes[g]),
            .box_valid (slot_valid[g]),
            .hit       (hit_vec[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            chroma2_reg <= (op1_reg == OP_CHROMA);
            smp2_reg    <= smp1_reg;
        end
        if (en3)
        begin
            chroma3_reg <= chroma2_reg;
            smp3_reg    <= smp2_reg;
            hit3_reg    <= hit_vec;
        end
    end

    // ---------------- stage 4: merge and output ----------------
    always_comb
    begin
        outline_next = |hit3_reg;
        if (outline_next)
        begin
            out_next = chroma3_reg ? chroma_color_reg
                                   : {{(SAMPLE_BITS-LUMA_BITS){1'b0}}, luma_color_reg};
        end
        else
        begin
            out_next = chroma3_reg ? smp3_reg
                                   : {{(SAMPLE_BITS-LUMA_BITS){1'b0}}, smp3_reg[LUMA_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_reg     <= out_next;
            outline_reg <= outline_next;
        end
    end

    assign pix_out.valid      = v4_reg;
    assign pix_out.sample_out = out_reg;
    assign pix_out.on_outline = outline_reg;

    // ---------------- checks ----------------
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.clear |=> (slot_valid == '0))
        else $error("slot table not empty after clear");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !pix_out.ready))
        else $error("input stalled with a bubble in the pipeline");

    a_luma_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && !chroma2_reg) |=> (smp3_reg == smp2_reg || !chroma3_reg) &&
        (out_next[SAMPLE_BITS-1:LUMA_BITS] == '0))
        else $error("luma beat carries nonzero upper byte");

endmodule

`default_nettype wire

// ===== bench/tb_nv12_bounding_box_overlay.sv =====
`timescale 1ns / 100ps
// Testbench for nv12_bounding_box_overlay: box loads, clears, luma/chroma outline hits.
// Depends on rtl/nbo_pkg.sv, rtl/nbo_if.sv and the overlay RTL; results checked in order.

module tb_nv12_bounding_box_overlay;
    import nbo_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, writes are dropped

    typedef struct packed {
        logic [1:0]             op;
        logic [4:0]             slot;
        coord_t                 left, top, right, bottom, pos_x, pos_y;
        logic [SAMPLE_BITS-1:0] value;
    } pix_beat_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pix;
        logic                   hit;
    } px_result_t;

    logic clk;
    logic rst_n;

    nbo_in_if  pix_in();
    nbo_out_if pix_out();
    nbo_cfg_if cfg();

    nv12_bounding_box_overlay u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    // overlay shadow state
    logic [THICK_BITS-1:0]  thick_reg;
    logic [LUMA_BITS-1:0]   luma_reg;
    logic [SAMPLE_BITS-1:0] chroma_reg;
    bit                     box_valid [NUM_SLOTS];
    int                     box_l [NUM_SLOTS];
    int                     box_tp [NUM_SLOTS];
    int                     box_r [NUM_SLOTS];
    int                     box_b [NUM_SLOTS];

    px_result_t pending_px[$];

    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;
    int n_in_beats, n_out_beats, n_outline, n_reg_writes, n_errors;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("%0t: timeout, %0d results still pending", $time, pending_px.size());
        $display("FAIL");
        $finish;
    end

    function automatic int eff_rings();
        return (thick_reg >= 1 && thick_reg <= THICK_MAX) ? int'(thick_reg) : int'(THICK_DEF);
    endfunction

    function automatic bit on_rect_edge(int x, int y, int l, int t, int r, int b);
        return ((y == t || y == b) && x >= l && x <= r) ||
               ((x == l || x == r) && y >= t && y <= b);
    endfunction

    function automatic bit outline_hit(int x, int y, bit chroma);
        int l, t, r, b, rings;
        rings = eff_rings();
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (!box_valid[s])
                continue;
            for (int i = 0; i < rings; i++)
            begin
                l = box_l[s] + i;
                r = box_r[s] - i;
                t = box_tp[s] + i;
                b = box_b[s] - i;
                if (l > r || t > b)
                    break;
                // chroma bounds are halved after the inset; all nonnegative here
                if (chroma)
                begin
                    l = l / 2;
                    r = r / 2;
                    t = t / 2;
                    b = b / 2;
                end
                if (on_rect_edge(x, y, l, t, r, b))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_overlay(pix_beat_t bt);
        px_result_t want;
        bit chroma;
        case (bt.op)
            OP_LOAD:
            begin
                box_l[bt.slot]     = int'({bt.left[COORD_BITS-1:1], 1'b0});
                box_tp[bt.slot]    = int'({bt.top[COORD_BITS-1:1], 1'b0});
                box_r[bt.slot]     = int'({bt.right[COORD_BITS-1:1], 1'b0});
                box_b[bt.slot]     = int'({bt.bottom[COORD_BITS-1:1], 1'b0});
                box_valid[bt.slot] = 1'b1;
            end
            OP_CLEAR:
                foreach (box_valid[s])
                    box_valid[s] = 1'b0;
            default:
            begin
                chroma   = (bt.op == OP_CHROMA);
                want.hit = outline_hit(int'(bt.pos_x), int'(bt.pos_y), chroma);
                if (want.hit)
                    want.pix = chroma ? chroma_reg : {8'h00, luma_reg};
                else
                    want.pix = chroma ? bt.value : {8'h00, bt.value[7:0]};
                pending_px.push_back(want);
            end
        endcase
    endfunction

    // output checker
    always @(posedge clk)
    begin : check_out
        px_result_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            n_out_beats++;
            if (pending_px.size() == 0)
            begin
                n_errors++;
                $display("%0t: ERROR output beat with nothing expected: %s=%h on_outline=%b",
                         $time, "sample_out", pix_out.sample_out, pix_out.on_outline);
            end
            else
            begin
                want = pending_px.pop_front();
                if (want.hit)
                    n_outline++;
                if (pix_out.sample_out !== want.pix)
                begin
                    n_errors++;
                    $display("%0t: ERROR sample_out expected %h actual %h",
                             $time, want.pix, pix_out.sample_out);
                end
                if (pix_out.on_outline !== want.hit)
                begin
                    n_errors++;
                    $display("%0t: ERROR on_outline expected %b actual %b",
                             $time, want.hit, pix_out.on_outline);
                end
            end
        end
    end

    // sink side: random stall bursts
    initial
    begin
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
        end
    end

    task automatic send_beat(pix_beat_t bt);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        pix_in.valid        <= 1'b1;
        pix_in.op           <= bt.op;
        pix_in.slot         <= bt.slot;
        pix_in.box_left     <= bt.left;
        pix_in.box_top      <= bt.top;
        pix_in.box_right    <= bt.right;
        pix_in.box_bottom   <= bt.bottom;
        pix_in.pos_x        <= bt.pos_x;
        pix_in.pos_y        <= bt.pos_y;
        pix_in.sample_value <= bt.value;
        do @(posedge clk); while (!pix_in.ready);
        predict_overlay(bt);
        n_in_beats++;
    endtask

    // unused fields carry random values so every input bit toggles
    function automatic pix_beat_t noise_beat();
        pix_beat_t bt;
        bt.op     = 2'($urandom);
        bt.slot   = 5'($urandom);
        bt.left   = coord_t'($urandom);
        bt.top    = coord_t'($urandom);
        bt.right  = coord_t'($urandom);
        bt.bottom = coord_t'($urandom);
        bt.pos_x  = coord_t'($urandom);
        bt.pos_y  = coord_t'($urandom);
        bt.value  = 16'($urandom);
        return bt;
    endfunction

    task automatic send_load(int slot, int l, int t, int r, int b);
        pix_beat_t bt;
        bt        = noise_beat();
        bt.op     = OP_LOAD;
        bt.slot   = 5'(slot);
        bt.left   = coord_t'(l);
        bt.top    = coord_t'(t);
        bt.right  = coord_t'(r);
        bt.bottom = coord_t'(b);
        send_beat(bt);
    endtask

    task automatic send_clear();
        pix_beat_t bt;
        bt    = noise_beat();
        bt.op = OP_CLEAR;
        send_beat(bt);
    endtask

    task automatic send_pixel(logic [1:0] op, int x, int y, logic [15:0] value);
        pix_beat_t bt;
        bt       = noise_beat();
        bt.op    = op;
        bt.pos_x = coord_t'(x);
        bt.pos_y = coord_t'(y);
        bt.value = value;
        send_beat(bt);
    endtask

    // drop valid before waiting so the last beat is not taken twice
    task automatic drain_results();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    // loads leave no result, so give the 4-stage pipe time to settle
    task automatic wait_idle();
        drain_results();
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_THICKNESS:    thick_reg  = data[THICK_BITS-1:0];
            REG_LUMA_COLOR:   luma_reg   = data[LUMA_BITS-1:0];
            REG_CHROMA_COLOR: chroma_reg = data;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic program_regs(logic [3:0] thick, logic [7:0] luma, logic [15:0] chroma);
        write_reg(REG_THICKNESS, {12'h000, thick});
        write_reg(REG_LUMA_COLOR, {8'h00, luma});
        write_reg(REG_CHROMA_COLOR, chroma);
        cfg.valid <= 1'b0;
    endtask

    function automatic int span(int lo, int hi);
        int tmp;
        if (hi < lo)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        return lo + $urandom_range(0, hi - lo);
    endfunction

    // position on or next to a ring of some loaded box
    task automatic near_outline(bit chroma, output int x, output int y);
        int s, i, tries;
        s = -1;
        for (tries = 0; tries < 8 && s < 0; tries++)
        begin
            i = $urandom_range(0, NUM_SLOTS - 1);
            if (box_valid[i])
                s = i;
        end
        if (s < 0)
        begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
            return;
        end
        i = $urandom_range(0, eff_rings());
        if ($urandom_range(0, 1))
        begin
            x = ($urandom_range(0, 1) ? box_l[s] + i : box_r[s] - i) + $urandom_range(0, 2) - 1;
            y = span(box_tp[s] - 2, box_b[s] + 2);
        end
        else
        begin
            y = ($urandom_range(0, 1) ? box_tp[s] + i : box_b[s] - i) + $urandom_range(0, 2) - 1;
            x = span(box_l[s] - 2, box_r[s] + 2);
        end
        if (chroma)
        begin
            x = x >>> 1;
            y = y >>> 1;
        end
    endtask

    task automatic load_random_box();
        int l, t;
        l = $urandom_range(0, 4095);
        t = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0)
            send_load($urandom_range(0, NUM_SLOTS - 1), l, t,
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        else
            send_load($urandom_range(0, NUM_SLOTS - 1), l, t,
                      l + $urandom_range(0, 48), t + $urandom_range(0, 48));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_passthrough();
        send_pixel(OP_LUMA, 0, 0, 16'hFFFF);
        send_pixel(OP_CHROMA, 4095, 4095, 16'hA5C3);
        send_pixel(OP_LUMA, 4095, 0, 16'h0000);
    endtask

    task automatic test_box_hits();
        // odd corners round down to 100,50 .. 200,150
        send_load(0, 101, 51, 201, 151);
        send_pixel(OP_LUMA, 100, 50, 16'h1234);
        send_pixel(OP_LUMA, 150, 150, 16'h5678);
        send_pixel(OP_LUMA, 101, 51, 16'h9ABC);
        send_pixel(OP_CHROMA, 50, 25, 16'h1357);
        send_pixel(OP_CHROMA, 100, 75, 16'h2468);
        send_pixel(OP_CHROMA, 75, 40, 16'hFEDC);
    endtask

    task automatic test_coord_extremes();
        send_load(31, 4095, 4095, 4095, 4095);
        send_pixel(OP_LUMA, 4094, 4094, 16'h00AA);
        send_pixel(OP_CHROMA, 2047, 2047, 16'h0F0F);
        send_load(1, 0, 0, 4095, 4095);
        send_pixel(OP_LUMA, 0, 4094, 16'hFF55);
        send_pixel(OP_LUMA, 4095, 0, 16'h33CC);
    endtask

    task automatic test_rings_and_regs();
        wait_idle();
        program_regs(4'd10, 8'hFF, 16'h0000);
        send_pixel(OP_LUMA, 109, 80, 16'h0011);     // innermost ring
        send_pixel(OP_LUMA, 110, 80, 16'h0022);     // just inside it
        send_pixel(OP_CHROMA, 54, 40, 16'h4321);
        send_load(2, 300, 300, 200, 200);           // inverted box draws nothing
        send_pixel(OP_LUMA, 200, 250, 16'h0033);
        wait_idle();
        write_reg(REG_SPARE, 16'h0005);
        write_reg(REG_THICKNESS, 16'h0000);         // zero acts as one ring
        cfg.valid <= 1'b0;
        send_pixel(OP_LUMA, 101, 60, 16'h0044);
        send_pixel(OP_LUMA, 100, 60, 16'h0055);
    endtask

    task automatic test_clear();
        send_clear();
        send_pixel(OP_LUMA, 100, 50, 16'h0066);
    endtask

    task automatic run_phase(int n, logic [3:0] thick, logic [7:0] luma,
                             logic [15:0] chroma, bit gaps, bit stalls);
        int sel, x, y;
        logic [1:0] op;
        wait_idle();
        program_regs(thick, luma, chroma);
        src_gaps    = gaps;
        sink_stalls = stalls;
        repeat (3) load_random_box();
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
                drain_results();    // sender holds off until every result is back
            sel = $urandom_range(0, 99);
            op  = $urandom_range(0, 1) ? OP_LUMA : OP_CHROMA;
            if (sel < 3)
                send_clear();
            else if (sel < 12)
                load_random_box();
            else if (sel < 25)
                send_pixel(op, $urandom_range(0, 4095), $urandom_range(0, 4095), 16'($urandom));
            else
            begin
                near_outline(op == OP_CHROMA, x, y);
                send_pixel(op, x, y, 16'($urandom));
            end
        end
    endtask

    task automatic test_random_phases();
        run_phase(105, 4'd1, 8'h00, 16'hFFFF, 1'b1, 1'b1);
        run_phase(105, 4'd10, 8'hFF, 16'h0000, 1'b1, 1'b0);
        run_phase(105, 4'd0, 8'($urandom), 16'($urandom), 1'b0, 1'b1);
        run_phase(105, 4'd15, 8'($urandom), 16'($urandom), 1'b1, 1'b1);
        run_phase(105, 4'd4, 8'($urandom), 16'($urandom), 1'b1, 1'b1);
        // closing stretch runs at full rate on both sides
        run_phase(105, 4'($urandom_range(2, 9)), 8'($urandom), 16'($urandom), 1'b0, 1'b0);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        pix_in.valid        <= 1'b0;
        pix_in.op           <= OP_LOAD;
        pix_in.slot         <= '0;
        pix_in.box_left     <= '0;
        pix_in.box_top      <= '0;
        pix_in.box_right    <= '0;
        pix_in.box_bottom   <= '0;
        pix_in.pos_x        <= '0;
        pix_in.pos_y        <= '0;
        pix_in.sample_value <= '0;
        cfg.valid           <= 1'b0;
        cfg.index           <= REG_THICKNESS;
        cfg.data            <= '0;
        thick_reg  = THICK_DEF;
        luma_reg   = LUMA_COLOR_DEF;
        chroma_reg = CHROMA_COLOR_DEF;
        foreach (box_valid[s])
        begin
            box_valid[s] = 1'b0;
            box_l[s]     = 0;
            box_tp[s]    = 0;
            box_r[s]     = 0;
            box_b[s]     = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_box_hits();
        test_coord_extremes();
        test_rings_and_regs();
        test_clear();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge clk);
        $display("Sent %0d pixel-side beats and %0d register writes %s.",
                 n_in_beats, n_reg_writes, "(thickness 0..15, color extremes)");
        $display("Checked %0d output beats, %0d of them on a box outline; %0d mismatches.",
                 n_out_beats, n_outline, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
